[src/sdm_pkg.sv]
// ----------------------------------------------------------------------------
// sdm_pkg: shared types and constants of the sized signed divider
// Request field layout, function codes and the control word that travels
// with each request down the divider pipeline.
// ----------------------------------------------------------------------------
package sdm_pkg;

    localparam logic FUNC_DIV = 1'b0;
    localparam logic FUNC_MOD = 1'b1;

    // s_axis_tdata layout, lowest bit first
    localparam int DL_LSB    = 0;
    localparam int DH_LSB    = 64;
    localparam int DB_LSB    = 128;
    localparam int VV_LSB    = 133;
    localparam int VB_LSB    = 197;
    localparam int RB_LSB    = 201;
    localparam int S_TDATA_W = 208;
    localparam int M_TDATA_W = 64;

    typedef struct packed {
        logic       func;
        logic       neg;
        logic       dbz;
        logic [3:0] rsz;
    } t_ctl;

endpackage

[src/sized_signed_divide_modulo.sv]
// ----------------------------------------------------------------------------
// sized_signed_divide_modulo: pipelined signed divide / modulo, sized operands
// Dividend of 1..2*OPERAND_BYTES bytes, divisor and result of 1..OPERAND_BYTES
// bytes, truncating toward zero, zero divisor flagged with a zero result.
//
// Use:
//   s_axis carries one request per handshake: tuser selects divide (0) or
//   modulo (1), tdata holds the operands and their byte sizes.
//   m_axis returns one result per request, in request order: tdata is the
//   result masked to its size, tuser is the divide-by-zero flag.
// Pipeline: one conditioning stage, one restoring step per dividend bit in a
//   row of cells, and one sign-fix / output stage between request and result.
// Throughput: one request per cycle while the output is not stalled; every stage carries its own valid bit.
// Stall: when m_axis_tready is low the result holds and the cells behind it
//   keep filling their empty slots; s_axis_tready drops only once the whole
//   row is full.
// Reset: synchronous, active low; empties every stage, nothing else to clear.
// ----------------------------------------------------------------------------
module sized_signed_divide_modulo import sdm_pkg::*; #(
    parameter int OPERAND_BYTES = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // dividend_low[63:0], dividend_high[127:64], dividend_bytes[132:128],
    // divisor_value[196:133], divisor_bytes[200:197], result_bytes[204:201]
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    // func[0]
    input  logic                 s_axis_tuser,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // result_value[63:0]
    output logic [M_TDATA_W-1:0] m_axis_tdata,
    // divide_by_zero[0]
    output logic                 m_axis_tuser
);
    localparam int OW = 8 * OPERAND_BYTES;
    localparam int DW = 2 * OW;

    logic          vld [DW+1];
    logic          rdy [DW+1];
    t_ctl          ctl [DW+1];
    logic [OW-1:0] rem [DW+1];
    logic [DW-1:0] dq  [DW+1];
    logic [OW-1:0] bu  [DW+1];

    sdm_prep #(.OPERAND_BYTES(OPERAND_BYTES)) u_prep (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (s_axis_tvalid),
        .o_ready          (s_axis_tready),
        .i_func           (s_axis_tuser),
        .i_dividend_low   (s_axis_tdata[DL_LSB +: 64]),
        .i_dividend_high  (s_axis_tdata[DH_LSB +: 64]),
        .i_dividend_bytes (s_axis_tdata[DB_LSB +: 5]),
        .i_divisor_value  (s_axis_tdata[VV_LSB +: 64]),
        .i_divisor_bytes  (s_axis_tdata[VB_LSB +: 4]),
        .i_result_bytes   (s_axis_tdata[RB_LSB +: 4]),
        .o_valid          (vld[0]),
        .i_ready          (rdy[0]),
        .o_ctl            (ctl[0]),
        .o_dq             (dq[0]),
        .o_bu             (bu[0])
    );

    assign rem[0] = '0;

    for (genvar k = 0; k < DW; k++) begin : g_cell
        sdm_cell #(.OPERAND_BYTES(OPERAND_BYTES)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (vld[k]),
            .o_ready (rdy[k]),
            .i_ctl   (ctl[k]),
            .i_rem   (rem[k]),
            .i_dq    (dq[k]),
            .i_bu    (bu[k]),
            .o_valid (vld[k+1]),
            .i_ready (rdy[k+1]),
            .o_ctl   (ctl[k+1]),
            .o_rem   (rem[k+1]),
            .o_dq    (dq[k+1]),
            .o_bu    (bu[k+1])
        );
    end

    sdm_post #(.OPERAND_BYTES(OPERAND_BYTES)) u_post (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (vld[DW]),
        .o_ready  (rdy[DW]),
        .i_ctl    (ctl[DW]),
        .i_rem    (rem[DW]),
        .i_quo    (dq[DW][OW-1:0]),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_result (m_axis_tdata),
        .o_dbz    (m_axis_tuser)
    );

endmodule

[src/sdm_prep.sv]
// ----------------------------------------------------------------------------
// sdm_prep: operand conditioning stage
// Clamps the sizes, masks both operands, takes their magnitudes and works out
// the sign of the result and the zero-divisor flag.
// ----------------------------------------------------------------------------
module sdm_prep import sdm_pkg::*; #(
    parameter int OPERAND_BYTES = 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic                       i_func,
    input  logic [63:0]                i_dividend_low,
    input  logic [63:0]                i_dividend_high,
    input  logic [4:0]                 i_dividend_bytes,
    input  logic [63:0]                i_divisor_value,
    input  logic [3:0]                 i_divisor_bytes,
    input  logic [3:0]                 i_result_bytes,
    output logic                       o_valid,
    input  logic                       i_ready,
    output t_ctl                       o_ctl,
    output logic [16*OPERAND_BYTES-1:0] o_dq,
    output logic [8*OPERAND_BYTES-1:0]  o_bu
);
    localparam int OW = 8 * OPERAND_BYTES;
    localparam int DW = 2 * OW;
    localparam int NB = 2 * OPERAND_BYTES;

    logic [4:0]    dsz;
    logic [3:0]    vsz;
    logic [3:0]    rsz;
    logic [127:0]  a_cat;
    logic [DW-1:0] a_in;
    logic [DW-1:0] a_mask;
    logic [DW-1:0] a_m;
    logic [DW-1:0] a_mag;
    logic [OW-1:0] b_in;
    logic [OW-1:0] b_mask;
    logic [OW-1:0] b_m;
    logic [OW-1:0] b_mag;
    logic          an;
    logic          bn;
    t_ctl          n_ctl;

    logic          r_valid;
    t_ctl          r_ctl;
    logic [DW-1:0] r_dq;
    logic [OW-1:0] r_bu;

    always_comb begin
        dsz = (i_dividend_bytes == 5'd0) ? 5'd1 :
              (i_dividend_bytes > 5'(NB)) ? 5'(NB) : i_dividend_bytes;
        vsz = (i_divisor_bytes == 4'd0) ? 4'd1 :
              (i_divisor_bytes > 4'(OPERAND_BYTES)) ? 4'(OPERAND_BYTES) : i_divisor_bytes;
        rsz = (i_result_bytes == 4'd0) ? 4'd1 :
              (i_result_bytes > 4'(OPERAND_BYTES)) ? 4'(OPERAND_BYTES) : i_result_bytes;

        a_cat = {i_dividend_high, i_dividend_low};
        a_in  = a_cat[DW-1:0];
        an    = 1'b0;
        for (int b = 0; b < NB; b++) begin
            a_mask[b*8 +: 8] = (5'(b) < dsz) ? 8'hFF : 8'h00;
            if (5'(b + 1) == dsz) begin
                an = a_in[b*8+7];
            end
        end
        a_m   = a_in & a_mask;
        a_mag = an ? ((~a_m + DW'(1)) & a_mask) : a_m;

        b_in = i_divisor_value[OW-1:0];
        bn   = 1'b0;
        for (int b = 0; b < OPERAND_BYTES; b++) begin
            b_mask[b*8 +: 8] = (4'(b) < vsz) ? 8'hFF : 8'h00;
            if (4'(b + 1) == vsz) begin
                bn = b_in[b*8+7];
            end
        end
        b_m   = b_in & b_mask;
        b_mag = bn ? ((~b_m + OW'(1)) & b_mask) : b_m;

        n_ctl.func = i_func;
        n_ctl.neg  = (i_func == FUNC_MOD) ? an : (an ^ bn);
        n_ctl.dbz  = (b_m == '0);
        n_ctl.rsz  = rsz;
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (i_valid && o_ready) begin
            r_ctl <= n_ctl;
            r_dq  <= a_mag;
            r_bu  <= b_mag;
        end
    end

    assign o_valid = r_valid;
    assign o_ctl   = r_ctl;
    assign o_dq    = r_dq;
    assign o_bu    = r_bu;

endmodule

[src/sdm_cell.sv]
// ----------------------------------------------------------------------------
// sdm_cell: one restoring division step
// Shifts the next dividend bit into the partial remainder, subtracts the
// divisor when it fits and shifts the quotient bit in at the bottom.
// ----------------------------------------------------------------------------
module sdm_cell import sdm_pkg::*; #(
    parameter int OPERAND_BYTES = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  t_ctl                        i_ctl,
    input  logic [8*OPERAND_BYTES-1:0]  i_rem,
    input  logic [16*OPERAND_BYTES-1:0] i_dq,
    input  logic [8*OPERAND_BYTES-1:0]  i_bu,
    output logic                        o_valid,
    input  logic                        i_ready,
    output t_ctl                        o_ctl,
    output logic [8*OPERAND_BYTES-1:0]  o_rem,
    output logic [16*OPERAND_BYTES-1:0] o_dq,
    output logic [8*OPERAND_BYTES-1:0]  o_bu
);
    localparam int OW = 8 * OPERAND_BYTES;
    localparam int DW = 2 * OW;

    logic [OW-1:0] shifted;
    logic          ge;
    logic [OW-1:0] n_rem;
    logic [DW-1:0] n_dq;

    logic          r_valid;
    t_ctl          r_ctl;
    logic [OW-1:0] r_rem;
    logic [DW-1:0] r_dq;
    logic [OW-1:0] r_bu;

    // remainder stays below the divisor (at most 2^(OW-1)), so OW-1 bits carry it
    always_comb begin
        shifted = {i_rem[OW-2:0], i_dq[DW-1]};
        ge      = (shifted >= i_bu);
        n_rem   = ge ? (shifted - i_bu) : shifted;
        n_dq    = {i_dq[DW-2:0], ge};
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (i_valid && o_ready) begin
            r_ctl <= i_ctl;
            r_rem <= n_rem;
            r_dq  <= n_dq;
            r_bu  <= i_bu;
        end
    end

    assign o_valid = r_valid;
    assign o_ctl   = r_ctl;
    assign o_rem   = r_rem;
    assign o_dq    = r_dq;
    assign o_bu    = r_bu;

    a_rem_below_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !r_ctl.dbz) |-> (r_rem < r_bu))
        else $error("partial remainder not below divisor");

    a_divisor_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !r_ctl.dbz) |-> (r_bu != '0))
        else $error("zero divisor without flag");

    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $past(i_valid && o_ready)) |-> r_valid)
        else $error("accepted request lost in cell");

endmodule

[src/sdm_post.sv]
// ----------------------------------------------------------------------------
// sdm_post: result sign fix and output register
// Picks quotient or remainder, applies the result sign, masks to the result
// size and holds the result until the receiver takes it.
// ----------------------------------------------------------------------------
module sdm_post import sdm_pkg::*; #(
    parameter int OPERAND_BYTES = 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  t_ctl                       i_ctl,
    input  logic [8*OPERAND_BYTES-1:0] i_rem,
    input  logic [8*OPERAND_BYTES-1:0] i_quo,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [M_TDATA_W-1:0]       o_result,
    output logic                       o_dbz
);
    localparam int OW = 8 * OPERAND_BYTES;

    logic [OW-1:0] sel;
    logic [OW-1:0] sgn;
    logic [OW-1:0] r_mask;
    logic [OW-1:0] n_res;

    logic          r_valid;
    logic [OW-1:0] r_res;
    logic          r_dbz;

    always_comb begin
        sel = (i_ctl.func == FUNC_MOD) ? i_rem : i_quo;
        sgn = i_ctl.neg ? (~sel + OW'(1)) : sel;
        for (int b = 0; b < OPERAND_BYTES; b++) begin
            r_mask[b*8 +: 8] = (4'(b) < i_ctl.rsz) ? 8'hFF : 8'h00;
        end
        n_res = i_ctl.dbz ? '0 : (sgn & r_mask);
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (i_valid && o_ready) begin
            r_res <= n_res;
            r_dbz <= i_ctl.dbz;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = M_TDATA_W'(r_res);
    assign o_dbz    = r_dbz;

    a_dbz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_dbz) |-> (r_res == '0))
        else $error("divide by zero with nonzero result");

    a_hold_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !i_ready) |=> (r_valid && $stable(r_res) && $stable(r_dbz)))
        else $error("stalled result changed");

    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $past(i_valid && o_ready)) |-> r_valid)
        else $error("accepted request lost at output");

endmodule

[tb/sized_signed_divide_modulo_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sized_signed_divide_modulo_tb: self-checking bench of the sized divider
// A queue-fed driver offers divide / modulo requests on the input stream and
// a monitor compares each result with a local predictor, in request order.
// Directed corner requests come first, then random ones under several
// sender-idle and receiver-stall mixes, plus one long output hold-off that
// fills the pipeline and backs up the input.
// ----------------------------------------------------------------------------
module sized_signed_divide_modulo_tb import sdm_pkg::*; ();

    localparam int LATENCY     = 16 * 8 + 2;
    localparam int HOLD_CYCLES = 600;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct packed {
        logic        func;
        logic [63:0] dl;
        logic [63:0] dh;
        logic [4:0]  db;
        logic [63:0] vv;
        logic [3:0]  vb;
        logic [3:0]  rb;
    } t_req;

    typedef struct packed {
        logic [63:0] value;
        logic        dbz;
    } t_res;

    logic                 i_clk;
    logic                 i_rst_n       = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    // dividend_low, dividend_high, dividend_bytes, divisor_value,
    // divisor_bytes, result_bytes
    logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
    // func
    logic                 s_axis_tuser  = 1'b0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    // result_value
    logic [M_TDATA_W-1:0] m_axis_tdata;
    // divide_by_zero
    logic                 m_axis_tuser;

    t_req request_q[$];
    t_res result_q[$];
    t_req offered_req;
    t_res want;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    bit hold_arm       = 1'b0;
    bit hold_taken     = 1'b0;
    int hold_left      = 0;

    int cycle_cnt   = 0;
    int n_errors    = 0;
    int n_accepted  = 0;
    int n_checked   = 0;
    int n_dbz       = 0;
    int n_mod       = 0;
    int n_backpress = 0;

    sized_signed_divide_modulo i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // signed truncating divide / modulo of sized operands
    function automatic t_res divmod_result(t_req r);
        int unsigned  dsz, vsz, rsz;
        logic [127:0] dmask, a, q, rm;
        logic [63:0]  vmask, rmask, bm, bu, res;
        logic         an, bn, neg;
        t_res         o;
        dsz = (r.db == 0) ? 1 : (r.db > 16) ? 16 : r.db;
        vsz = (r.vb == 0) ? 1 : (r.vb > 8) ? 8 : r.vb;
        rsz = (r.rb == 0) ? 1 : (r.rb > 8) ? 8 : r.rb;
        dmask = (dsz == 16) ? '1 : ((128'd1 << (dsz * 8)) - 128'd1);
        vmask = (vsz == 8) ? '1 : ((64'd1 << (vsz * 8)) - 64'd1);
        rmask = (rsz == 8) ? '1 : ((64'd1 << (rsz * 8)) - 64'd1);
        a  = {r.dh, r.dl} & dmask;
        an = a[dsz * 8 - 1];
        if (an) a = (~a + 128'd1) & dmask;
        bm = r.vv & vmask;
        bn = bm[vsz * 8 - 1];
        bu = bn ? ((~bm + 64'd1) & vmask) : bm;
        if (bu == 64'd0) begin
            o.value = '0;
            o.dbz   = 1'b1;
            return o;
        end
        q   = a / {64'd0, bu};
        rm  = a % {64'd0, bu};
        res = (r.func == FUNC_MOD) ? rm[63:0] : q[63:0];
        neg = (r.func == FUNC_MOD) ? an : (an ^ bn);
        if (neg) res = ~res + 64'd1;
        o.value = res & rmask;
        o.dbz   = 1'b0;
        return o;
    endfunction

    // operand bits biased toward sign boundaries at a given byte size
    function automatic logic [63:0] pick_operand(int nbytes);
        logic [63:0] v;
        int          sz;
        sz = (nbytes < 1) ? 1 : (nbytes > 8) ? 8 : nbytes;
        v  = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            4: v = '0;
            5: v = '1;
            6: v = 64'd1 << (sz * 8 - 1);
            7: v = 64'($urandom_range(0, 15));
            8: v = ~64'($urandom_range(0, 15));
            9: v = (64'd1 << (sz * 8 - 1)) - 64'd1;
            default: ;
        endcase
        return v;
    endfunction

    function automatic t_req random_req();
        t_req r;
        r.func = 1'($urandom_range(0, 1));
        r.db = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(0, 31))
                                           : 5'($urandom_range(1, 16));
        r.vb = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15))
                                           : 4'($urandom_range(1, 8));
        r.rb = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15))
                                           : 4'($urandom_range(1, 8));
        r.dl = pick_operand((r.db > 8) ? 8 : r.db);
        r.dh = pick_operand((r.db > 8) ? r.db - 8 : 8);
        r.vv = pick_operand(r.vb);
        return r;
    endfunction

    task automatic add_req(logic func, logic [63:0] dl, logic [63:0] dh, logic [4:0] db,
                           logic [63:0] vv, logic [3:0] vb, logic [3:0] rb);
        t_req r;
        r.func = func;
        r.dl   = dl;
        r.dh   = dh;
        r.db   = db;
        r.vv   = vv;
        r.vb   = vb;
        r.rb   = rb;
        request_q.insert(request_q.size(), r);
    endtask

    task automatic add_random(int n);
        repeat (n) request_q.insert(request_q.size(), random_req());
    endtask

    task automatic drain();
        while (request_q.size() != 0 || s_axis_tvalid || result_q.size() != 0)
            @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                result_q.insert(result_q.size(), divmod_result(offered_req));
                n_accepted++;
                if (offered_req.func == FUNC_MOD) n_mod++;
            end
            if (s_axis_tvalid && !s_axis_tready) n_backpress++;
            if (!s_axis_tvalid || s_axis_tready) begin
                if (request_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    offered_req = request_q.pop_front();
                    s_axis_tdata                 <= {
                        3'b000, offered_req.rb, offered_req.vb, offered_req.vv,
                        offered_req.db, offered_req.dh, offered_req.dl
                    };
                    s_axis_tuser                 <= offered_req.func;
                    s_axis_tvalid                <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver
    always @(posedge i_clk) begin
        if (hold_arm && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left  = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (result_q.size() == 0) begin
                $error("unexpected result: result_value=%h divide_by_zero=%b",
                       m_axis_tdata, m_axis_tuser);
                n_errors++;
            end else begin
                want = result_q.pop_front();
                n_checked++;
                if (want.dbz) n_dbz++;
                if (m_axis_tdata !== want.value) begin
                    $error("result_value: expected %h, actual %h", want.value, m_axis_tdata);
                    n_errors++;
                end
                if (m_axis_tuser !== want.dbz) begin
                    $error("divide_by_zero: expected %b, actual %b", want.dbz, m_axis_tuser);
                    n_errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_cnt, result_q.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // small signed cases, one byte
        add_req(FUNC_DIV, 64'd7, 64'd0, 5'd1, 64'd2, 4'd1, 4'd1);
        add_req(FUNC_MOD, 64'hF9, 64'd0, 5'd1, 64'd2, 4'd1, 4'd1);
        add_req(FUNC_DIV, 64'hF9, 64'd0, 5'd1, 64'd2, 4'd1, 4'd1);
        add_req(FUNC_DIV, 64'd7, 64'd0, 5'd1, 64'hFE, 4'd1, 4'd1);
        add_req(FUNC_MOD, 64'd7, 64'd0, 5'd1, 64'hFE, 4'd1, 4'd1);
        // zero divisor, plain and masked away
        add_req(FUNC_DIV, 64'd12345, 64'd0, 5'd8, 64'd0, 4'd8, 4'd8);
        add_req(FUNC_MOD, 64'd12345, 64'd0, 5'd8, 64'd0, 4'd8, 4'd8);
        add_req(FUNC_MOD, 64'd99, 64'd0, 5'd2, 64'hFFFF_FF00, 4'd1, 4'd2);
        // most negative over minus one wraps
        add_req(FUNC_DIV, 64'h8000_0000_0000_0000, 64'd0, 5'd8, '1, 4'd8, 4'd8);
        add_req(FUNC_MOD, 64'h8000_0000_0000_0000, 64'd0, 5'd8, '1, 4'd8, 4'd8);
        add_req(FUNC_DIV, 64'd0, 64'h8000_0000_0000_0000, 5'd16, '1, 4'd8, 4'd8);
        // all-ones dividends and the largest positive one, at full width
        add_req(FUNC_DIV, '1, '1, 5'd16, 64'd3, 4'd8, 4'd8);
        add_req(FUNC_MOD, '1, '1, 5'd16, '1, 4'd8, 4'd8);
        add_req(FUNC_DIV, '1, 64'h7FFF_FFFF_FFFF_FFFF, 5'd16, 64'd7, 4'd8, 4'd8);
        // zero sizes read as one byte, oversize saturates
        add_req(FUNC_DIV, 64'h1234_5685, 64'd0, 5'd0, 64'h0303, 4'd0, 4'd0);
        add_req(FUNC_MOD, '1, 64'hF123_4567_89AB_CDEF, 5'd31, 64'hFFFF_FFFF_FFFF_FFFD,
                4'd15, 4'd15);
        add_req(FUNC_DIV, 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, 5'd17,
                64'd1000, 4'd9, 4'd9);
        // high word ignored at eight bytes or less
        add_req(FUNC_DIV, 64'h7FFF_FFFF_FFFF_FFFF, 64'hDEAD_BEEF_0BAD_F00D, 5'd8,
                64'd5, 4'd8, 4'd8);
        // result narrower than the quotient
        add_req(FUNC_DIV, '1, 64'h0000_0000_0000_00FF, 5'd9, 64'd3, 4'd1, 4'd1);
        add_req(FUNC_DIV, 64'd1 << 40, 64'd0, 5'd6, 64'd1, 4'd1, 4'd3);
        // most negative divisor, zero dividend, nine-byte negative dividend
        add_req(FUNC_DIV, '1, '1, 5'd16, 64'h8000_0000_0000_0000, 4'd8, 4'd8);
        add_req(FUNC_MOD, 64'd0, 64'd0, 5'd16, 64'h8000_0000_0000_0000, 4'd8, 4'd8);
        add_req(FUNC_MOD, 64'h0000_0000_0000_0010, 64'h80, 5'd9, 64'd6, 4'd1, 4'd8);

        add_random(150);
        drain();

        send_idle_pct  = 62;
        recv_stall_pct = 0;
        add_random(150);
        drain();

        send_idle_pct  = 0;
        recv_stall_pct = 62;
        add_random(150);
        drain();

        send_idle_pct  = 34;
        recv_stall_pct = 34;
        add_random(100);
        drain();

        // long output hold-off: pipeline fills and the input backs up
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_arm       = 1'b1;
        add_random(300);
        drain();

        $display("checked %0d results of %0d requests (%0d modulo, %0d divide-by-zero)",
                 n_checked, n_accepted, n_mod, n_dbz);
        $display("input held off for %0d cycles under output backpressure", n_backpress);
        if (n_errors == 0 && result_q.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

[filelist.f]
src/sdm_pkg.sv
src/sdm_prep.sv
src/sdm_cell.sv
src/sdm_post.sv
src/sized_signed_divide_modulo.sv
tb/sized_signed_divide_modulo_tb.sv
